/* hdl/qlte_pkg.sv */
// ----------------------------------------------------------------------------
// qlte_pkg
// Shared types and constants for the Q-learning table engine.
// ----------------------------------------------------------------------------
package qlte_pkg;

    localparam int POLICY_SLOTS_DEF       = 16;
    localparam int ACTIONS_PER_POLICY_DEF = 16;
    localparam logic [15:0] GAMMA_Q16     = 16'd64881;
    localparam logic [13:0] ID_BASE       = 14'd10000;
    localparam int IN_BITS                = 185;
    localparam int IN_BYTES_W             = 192;
    localparam int OUT_BITS               = 112;
    localparam int OUT_BYTES_W            = 112;
    localparam int RESULT_LIMIT           = 16;

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_SELECT = 2'd2,
        REQ_LIST   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_POL   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTHING  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND,       // scan policy slots for state_key
        S_FIND_WAIT,
        S_ASCAN,      // scan actions of found slot
        S_ASCAN_CHK,
        S_APPEND,
        S_NFIND,      // scan slots for next_state_key
        S_NSCAN,      // max Q over next slot
        S_NSCAN_CHK,
        S_OLDQ,
        S_OLDQ_WAIT,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_WRITE,
        S_SEL_SCAN,
        S_SEL_CHK,
        S_SEL_READ,
        S_SEL_READ_W,
        S_LIST_PICK,  // selection pass: find best remaining
        S_LIST_CHK,
        S_LIST_READ,
        S_LIST_READ_W,
        S_OUT
    } state_t;

endpackage

/* hdl/qlte_ram.sv */
// ----------------------------------------------------------------------------
// qlte_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module qlte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hdl/q_learning_table_engine.sv */
// ----------------------------------------------------------------------------
// q_learning_table_engine
// Tabular Q-learning store with epsilon-greedy select and top-k listing.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit first)                      | tuser | tlast
// s_      | in  | req_type, state_key, next_state_key,       | -     | -
//         |     | action_key, reward, alpha_in, epsilon,     |       |
//         |     | explore_draw, pick_draw, list_limit        |       |
// m_      | out | status, chosen_action, policy_number, new_q| explored | last
// Requests run one at a time through a sequencer on one RAM port per table
// and one shared compare / 34x34 multiplier in sequence; a list makes one
// pass over the actions for each listed item.
// Reset clears slot count and action totals; table RAMs are not cleared.
// s_tready is low while an item is in progress; a held result stalls the
// sequencer until m_tready.
// ----------------------------------------------------------------------------
module q_learning_table_engine #(
    parameter int POLICY_SLOTS       = qlte_pkg::POLICY_SLOTS_DEF,
    parameter int ACTIONS_PER_POLICY = qlte_pkg::ACTIONS_PER_POLICY_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type, state_key, next_state_key, action_key, reward, alpha_in,
    // epsilon, explore_draw, pick_draw, list_limit
    input  logic [qlte_pkg::IN_BYTES_W-1:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, chosen_action, policy_number, new_q
    output logic [qlte_pkg::OUT_BYTES_W-1:0] m_tdata,
    // explored
    output logic         m_tuser,
    output logic         m_tlast
);
    import qlte_pkg::*;

    localparam int SW = (POLICY_SLOTS > 1) ? $clog2(POLICY_SLOTS) : 1;
    localparam int AW = (ACTIONS_PER_POLICY > 1) ? $clog2(ACTIONS_PER_POLICY) : 1;
    localparam int CW = $clog2(ACTIONS_PER_POLICY + 1);
    localparam int PW = $clog2(POLICY_SLOTS + 1);
    localparam int EW = SW + AW;
    localparam int ED = 1 << EW;

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [7:0]  pol_state_reg [POLICY_SLOTS];
    logic [16:0] pol_alpha_reg [POLICY_SLOTS];
    logic [CW-1:0] pol_total_reg [POLICY_SLOTS];
    logic [PW-1:0] used_reg;

    // latched request
    logic [1:0]  req_reg;
    logic [7:0]  skey_reg, nkey_reg;
    logic [63:0] act_reg;
    logic signed [31:0] rew_reg;
    logic [16:0] alpha_in_reg, eps_reg;
    logic [15:0] xdraw_reg, pdraw_reg;
    logic [4:0]  maxc_reg;

    // work registers
    logic [PW-1:0] si_reg;       // slot scan index
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] ai_reg;       // action scan index
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [31:0] maxq_reg;
    logic [AW-1:0] best_reg;
    logic best_any_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] oldq_reg;
    logic [ACTIONS_PER_POLICY-1:0] done_reg;  // listed entries
    logic [4:0] emit_reg;
    logic [4:0] emitted_reg;

    // result holding register
    logic         ov_reg;
    logic [1:0]   o_status_reg;
    logic [63:0]  o_act_reg;
    logic [13:0]  o_pol_reg;
    logic [31:0]  o_q_reg;
    logic         o_expl_reg;
    logic         o_last_reg;

    // ---------------- RAMs ----------------
    logic          ram_we_a, ram_we_q;
    logic [EW-1:0] ram_addr;
    logic [63:0]   ram_wact, ram_ract;
    logic [31:0]   ram_wq, ram_rq;

    qlte_ram #(.WIDTH(64), .DEPTH(ED)) u_act (
        .aclk(aclk), .we(ram_we_a), .addr(ram_addr), .wdata(ram_wact), .rdata(ram_ract));
    qlte_ram #(.WIDTH(32), .DEPTH(ED)) u_q (
        .aclk(aclk), .we(ram_we_q), .addr(ram_addr), .wdata(ram_wq), .rdata(ram_rq));

    // ---------------- shared multiplier ----------------
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [63:0] floor_p;
    assign floor_p = 64'(mul_p >>> 16);   // arithmetic shift is floor

    // ---------------- handshake ----------------
    logic s_acc, m_acc;
    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = ov_reg && m_tready;

    assign m_tvalid = ov_reg;
    assign m_tuser  = o_expl_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {o_q_reg, o_pol_reg, o_act_reg, o_status_reg};

    // helpers
    logic [SW-1:0] si_idx;
    assign si_idx = si_reg[SW-1:0];
    logic slot_hit, slot_end;
    assign slot_end = (si_reg >= used_reg) || (si_reg >= PW'(POLICY_SLOTS));
    assign slot_hit = !slot_end && (pol_state_reg[si_idx] ==
                      ((state_reg == S_NFIND) ? nkey_reg : skey_reg)) &&
                      (req_reg != REQ_SELECT || pol_total_reg[si_idx] != '0);
    logic signed [31:0] ram_rq_s;
    assign ram_rq_s = ram_rq;

    // explore index: remainder by shift and subtract, one bit a cycle
    logic [15:0] pmod_reg;
    logic [4:0]  pstep_reg;
    logic [31:0] mod_div;
    logic [15:0] pmod_step;
    assign mod_div   = 32'(cnt_reg) << pstep_reg;
    assign pmod_step = (32'(pmod_reg) >= mod_div) ? 16'(32'(pmod_reg) - mod_div) : pmod_reg;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                if (req_reg == REQ_CREATE || (req_reg == REQ_LIST && maxc_reg == 5'd0)) begin
                    state_next = S_OUT;
                end else if (slot_hit) begin
                    state_next = S_FIND_WAIT;
                end else if (slot_end) begin
                    state_next = S_OUT;
                end
            end
            S_FIND_WAIT: begin
                unique case (req_reg)
                    REQ_UPDATE: state_next = S_ASCAN;
                    REQ_SELECT: state_next = S_SEL_SCAN;
                    REQ_LIST:   state_next = (cnt_reg == '0) ? S_OUT : S_LIST_PICK;
                    default:    state_next = S_OUT;
                endcase
            end
            S_ASCAN: begin
                if (ai_reg >= cnt_reg) begin
                    state_next = (cnt_reg >= CW'(ACTIONS_PER_POLICY)) ? S_OUT : S_APPEND;
                end else begin
                    state_next = S_ASCAN_CHK;
                end
            end
            S_ASCAN_CHK: state_next = (ram_ract == act_reg) ? S_NFIND : S_ASCAN;
            S_APPEND:    state_next = S_NFIND;
            S_NFIND: begin
                if (slot_hit || slot_end) begin
                    state_next = (slot_hit && pol_total_reg[si_idx] != '0) ? S_NSCAN : S_OLDQ;
                end
            end
            S_NSCAN:     state_next = (ai_reg >= cnt_reg) ? S_OLDQ : S_NSCAN_CHK;
            S_NSCAN_CHK: state_next = S_NSCAN;
            S_OLDQ:      state_next = S_OLDQ_WAIT;
            S_OLDQ_WAIT: state_next = S_MUL1;
            S_MUL1:      state_next = S_MUL2;
            S_MUL2:      state_next = S_MUL3;
            S_MUL3:      state_next = S_WRITE;
            S_WRITE:     state_next = S_OUT;
            S_SEL_SCAN: begin
                if (xdraw_reg < eps_reg) begin
                    state_next = (pstep_reg == 5'd0) ? S_SEL_READ : S_SEL_SCAN;
                end else if (ai_reg >= cnt_reg) begin
                    state_next = S_SEL_READ;
                end else begin
                    state_next = S_SEL_CHK;
                end
            end
            S_SEL_CHK:    state_next = S_SEL_SCAN;
            S_SEL_READ:   state_next = S_SEL_READ_W;
            S_SEL_READ_W: state_next = S_OUT;
            S_LIST_PICK:  state_next = (ai_reg >= cnt_reg) ? S_LIST_READ : S_LIST_CHK;
            S_LIST_CHK:   state_next = S_LIST_PICK;
            S_LIST_READ:  state_next = S_LIST_READ_W;
            S_LIST_READ_W: state_next = S_OUT;
            S_OUT: begin
                if (m_acc) begin
                    if (req_reg == REQ_LIST && o_last_reg == 1'b0 && emitted_reg != 5'd0) begin
                        state_next = S_LIST_PICK;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- RAM control ----------------
    logic signed [63:0] nq_full;
    logic signed [31:0] nq_sat;
    assign nq_full = 64'(oldq_reg) + acc_reg;
    always_comb begin
        if (nq_full > 64'sh7FFF_FFFF) begin
            nq_sat = 32'sh7FFF_FFFF;
        end else if (nq_full < -64'sh8000_0000) begin
            nq_sat = 32'sh8000_0000;
        end else begin
            nq_sat = nq_full[31:0];
        end
    end

    always_comb begin
        ram_we_a = 1'b0;
        ram_we_q = 1'b0;
        ram_wact = act_reg;
        ram_wq   = '0;
        ram_addr = {slot_reg, ai_reg[AW-1:0]};
        unique case (state_reg)
            S_APPEND: begin
                ram_we_a = 1'b1;
                ram_we_q = 1'b1;
                ram_addr = {slot_reg, cnt_reg[AW-1:0]};
            end
            S_NSCAN:  ram_addr = {si_idx, ai_reg[AW-1:0]};
            S_OLDQ:   ram_addr = {slot_reg, idx_reg};
            S_WRITE: begin
                ram_we_q = 1'b1;
                ram_wq   = nq_sat;
                ram_addr = {slot_reg, idx_reg};
            end
            S_SEL_READ, S_LIST_READ: ram_addr = {slot_reg, best_reg};
            default: ram_addr = {slot_reg, ai_reg[AW-1:0]};
        endcase
    end

    // ---------------- multiplier operands ----------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL1: begin
                mul_a = 34'(signed'({1'b0, GAMMA_Q16}));
                mul_b = 34'(maxq_reg);
            end
            S_MUL2: begin
                mul_a = 34'(signed'({1'b0, pol_alpha_reg[slot_reg]}));
                mul_b = acc_reg[33:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int k = 0; k < POLICY_SLOTS; k++) begin
                pol_total_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_acc) begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        req_reg      <= s_tdata[1:0];
                        skey_reg     <= s_tdata[9:2];
                        nkey_reg     <= s_tdata[17:10];
                        act_reg      <= s_tdata[81:18];
                        rew_reg      <= s_tdata[113:82];
                        alpha_in_reg <= s_tdata[130:114];
                        eps_reg      <= s_tdata[147:131];
                        xdraw_reg    <= s_tdata[163:148];
                        pdraw_reg    <= s_tdata[179:164];
                        maxc_reg     <= s_tdata[184:180];
                        si_reg       <= '0;
                        ai_reg       <= '0;
                        emitted_reg  <= '0;
                        done_reg     <= '0;
                        o_status_reg <= ST_OK;
                        o_act_reg    <= '0;
                        o_pol_reg    <= '0;
                        o_q_reg      <= '0;
                        o_expl_reg   <= 1'b0;
                        o_last_reg   <= 1'b1;
                    end
                end
                S_FIND: begin
                    if (req_reg == REQ_CREATE) begin
                        if (used_reg >= PW'(POLICY_SLOTS)) begin
                            o_status_reg <= ST_FULL;
                        end else begin
                            pol_state_reg[used_reg[SW-1:0]] <= skey_reg;
                            pol_alpha_reg[used_reg[SW-1:0]] <= alpha_in_reg;
                            pol_total_reg[used_reg[SW-1:0]] <= '0;
                            o_pol_reg <= ID_BASE + 14'(used_reg);
                            used_reg  <= used_reg + 1'b1;
                        end
                    end else if (req_reg == REQ_LIST && maxc_reg == 5'd0) begin
                        o_status_reg <= ST_NOTHING;
                    end else if (slot_hit) begin
                        slot_reg  <= si_idx;
                        cnt_reg   <= pol_total_reg[si_idx];
                        pmod_reg  <= pdraw_reg;
                        pstep_reg <= 5'd15;
                        emit_reg  <= (5'(pol_total_reg[si_idx]) < maxc_reg) ?
                                     5'(pol_total_reg[si_idx]) : maxc_reg;
                    end else if (slot_end) begin
                        o_status_reg <= ST_NO_POL;
                    end else begin
                        si_reg <= si_reg + 1'b1;
                    end
                end
                S_FIND_WAIT: begin
                    ai_reg       <= '0;
                    best_reg     <= '0;
                    best_any_reg <= 1'b0;
                    if (req_reg == REQ_LIST && cnt_reg == '0) begin
                        o_status_reg <= ST_NOTHING;
                    end
                end
                S_ASCAN: begin
                    if (ai_reg >= cnt_reg) begin
                        if (cnt_reg >= CW'(ACTIONS_PER_POLICY)) begin
                            o_status_reg <= ST_FULL;
                        end
                    end
                end
                S_ASCAN_CHK: begin
                    if (ram_ract == act_reg) begin
                        idx_reg <= ai_reg[AW-1:0];
                        si_reg  <= '0;
                    end else begin
                        ai_reg <= ai_reg + 1'b1;
                    end
                end
                S_APPEND: begin
                    idx_reg <= cnt_reg[AW-1:0];
                    pol_total_reg[slot_reg] <= cnt_reg + 1'b1;
                    si_reg  <= '0;
                end
                S_NFIND: begin
                    maxq_reg <= '0;
                    ai_reg   <= '0;
                    best_any_reg <= 1'b0;
                    if (slot_hit) begin
                        cnt_reg <= pol_total_reg[si_idx];
                    end else if (!slot_end) begin
                        si_reg <= si_reg + 1'b1;
                    end
                end
                S_NSCAN: begin
                    if (ai_reg < cnt_reg) begin
                        ai_reg <= ai_reg + 1'b1;
                    end
                end
                S_NSCAN_CHK: begin
                    if (!best_any_reg || ram_rq_s > maxq_reg) begin
                        maxq_reg <= ram_rq_s;
                    end
                    best_any_reg <= 1'b1;
                end
                S_OLDQ_WAIT: begin
                    oldq_reg <= ram_rq_s;
                end
                S_MUL1: begin
                    acc_reg <= 64'(rew_reg) + floor_p - 64'(oldq_reg);
                end
                S_MUL2: begin
                    acc_reg <= floor_p;
                end
                S_MUL3: begin
                    acc_reg <= acc_reg;
                end
                S_WRITE: begin
                    o_q_reg <= nq_sat;
                end
                S_SEL_SCAN: begin
                    if (xdraw_reg < eps_reg) begin
                        if (pstep_reg == 5'd0) begin
                            best_reg   <= pmod_step[AW-1:0];
                            o_expl_reg <= 1'b1;
                        end else begin
                            pmod_reg  <= pmod_step;
                            pstep_reg <= pstep_reg - 1'b1;
                        end
                    end else if (ai_reg < cnt_reg) begin
                        ai_reg <= ai_reg + 1'b1;
                    end
                end
                S_SEL_CHK: begin
                    if (!best_any_reg || ram_rq_s > maxq_reg) begin
                        maxq_reg <= ram_rq_s;
                        best_reg <= AW'(ai_reg - 1'b1);
                    end
                    best_any_reg <= 1'b1;
                end
                S_LIST_PICK: begin
                    if (ai_reg < cnt_reg) begin
                        ai_reg <= ai_reg + 1'b1;
                    end
                end
                S_LIST_CHK: begin
                    if (!done_reg[AW'(ai_reg - 1'b1)] &&
                        (!best_any_reg || ram_rq_s > maxq_reg)) begin
                        maxq_reg <= ram_rq_s;
                        best_reg <= AW'(ai_reg - 1'b1);
                        best_any_reg <= 1'b1;
                    end
                end
                S_LIST_READ: begin
                    done_reg[best_reg] <= 1'b1;
                    emitted_reg <= emitted_reg + 1'b1;
                end
                S_SEL_READ_W, S_LIST_READ_W: begin
                    o_act_reg  <= ram_ract;
                    o_last_reg <= (req_reg == REQ_LIST) ? (emitted_reg == emit_reg) : 1'b1;
                end
                S_OUT: begin
                    if (!ov_reg) begin
                        ov_reg       <= 1'b1;
                        ai_reg       <= '0;
                        best_any_reg <= 1'b0;
                    end
                end
                default: begin
                    ai_reg <= ai_reg;
                end
            endcase
        end
    end

    // S_OUT holds the result until it is taken; a list then goes back to
    // picking because o_last_reg stays low until the final item.

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= PW'(POLICY_SLOTS)) else $error("slot count overflow");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg |-> !s_tready) else $error("accept while result held");
`endif

endmodule

/* bench/qlte_checker.sv */
// ----------------------------------------------------------------------------
// qlte_checker
// Watches both channels of the Q-learning table engine, predicts the result
// items of every accepted request from its own copy of the tables, and
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module qlte_checker
    import qlte_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_BYTES_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_BYTES_W-1:0] m_tdata,
    input  logic                   m_tuser,
    input  logic                   m_tlast,
    output int                     fail_count,
    output int                     pending
);

    localparam int SLOTS = POLICY_SLOTS_DEF;
    localparam int ACTS  = ACTIONS_PER_POLICY_DEF;

    typedef struct packed {
        status_t     status;
        logic [63:0] action;
        logic [13:0] pol;
        logic [31:0] q;
        logic        expl;
        logic        last;
    } result_t;

    result_t     result_q[$];
    logic [7:0]  tbl_state[SLOTS];
    logic [16:0] tbl_alpha[SLOTS];
    int          tbl_total[SLOTS];
    int          used;
    logic [63:0] tbl_act[SLOTS][ACTS];
    logic signed [31:0] tbl_q[SLOTS][ACTS];

    assign pending = result_q.size();

    function automatic int find_slot(logic [7:0] key, bit need_acts);
        for (int i = 0; i < used; i++) begin
            if (tbl_state[i] == key && (!need_acts || tbl_total[i] > 0)) return i;
        end
        return -1;
    endfunction

    function automatic result_t mk(status_t st, logic [63:0] a, logic [13:0] p,
                                   logic [31:0] q, logic e, logic l);
        result_t r;
        r.status = st; r.action = a; r.pol = p; r.q = q; r.expl = e; r.last = l;
        return r;
    endfunction

    task automatic predict_request(logic [191:0] v);
        req_t        req;
        logic [7:0]  skey, nkey;
        logic [63:0] act;
        longint      reward, maxq, oldq, target, nq;
        logic [16:0] lr, eps;
        logic [15:0] xd, pd;
        int          maxc, s, n, idx, cnt, best, emit;
        bit          taken[ACTS];
        req    = req_t'(v[1:0]);
        skey   = v[9:2];
        nkey   = v[17:10];
        act    = v[81:18];
        reward = longint'($signed(v[113:82]));
        lr     = v[130:114];
        eps    = v[147:131];
        xd     = v[163:148];
        pd     = v[179:164];
        maxc   = v[184:180];
        case (req)
            REQ_CREATE: begin
                if (used >= SLOTS) begin
                    result_q.push_back(mk(ST_FULL, 0, 0, 0, 0, 1));
                end else begin
                    tbl_state[used] = skey;
                    tbl_alpha[used] = lr;
                    tbl_total[used] = 0;
                    result_q.push_back(mk(ST_OK, 0, ID_BASE + 14'(used), 0, 0, 1));
                    used++;
                end
            end
            REQ_UPDATE: begin
                s = find_slot(skey, 0);
                if (s < 0) begin
                    result_q.push_back(mk(ST_NO_POL, 0, 0, 0, 0, 1));
                    return;
                end
                idx = -1;
                for (int i = 0; i < tbl_total[s]; i++) begin
                    if (idx < 0 && tbl_act[s][i] == act) idx = i;
                end
                if (idx < 0) begin
                    if (tbl_total[s] >= ACTS) begin
                        result_q.push_back(mk(ST_FULL, 0, 0, 0, 0, 1));
                        return;
                    end
                    idx = tbl_total[s];
                    tbl_act[s][idx] = act;
                    tbl_q[s][idx] = 0;
                    tbl_total[s]++;
                end
                maxq = 0;
                n = find_slot(nkey, 0);
                if (n >= 0 && tbl_total[n] > 0) begin
                    maxq = tbl_q[n][0];
                    for (int i = 1; i < tbl_total[n]; i++) begin
                        if (tbl_q[n][i] > maxq) maxq = tbl_q[n][i];
                    end
                end
                oldq   = tbl_q[s][idx];
                target = reward + ((longint'(GAMMA_Q16) * maxq) >>> 16);
                nq     = oldq + ((longint'(tbl_alpha[s]) * (target - oldq)) >>> 16);
                if (nq > 64'sd2147483647) nq = 64'sd2147483647;
                if (nq < -64'sd2147483648) nq = -64'sd2147483648;
                tbl_q[s][idx] = 32'(nq);
                result_q.push_back(mk(ST_OK, 0, 0, 32'(nq), 0, 1));
            end
            REQ_SELECT: begin
                s = find_slot(skey, 1);
                if (s < 0) begin
                    result_q.push_back(mk(ST_NO_POL, 0, 0, 0, 0, 1));
                    return;
                end
                cnt = tbl_total[s];
                if (17'(xd) < eps) begin
                    result_q.push_back(mk(ST_OK, tbl_act[s][int'(pd) % cnt], 0, 0, 1, 1));
                end else begin
                    best = 0;
                    for (int i = 1; i < cnt; i++) begin
                        if (tbl_q[s][i] > tbl_q[s][best]) best = i;
                    end
                    result_q.push_back(mk(ST_OK, tbl_act[s][best], 0, 0, 0, 1));
                end
            end
            REQ_LIST: begin
                if (maxc == 0) begin
                    result_q.push_back(mk(ST_NOTHING, 0, 0, 0, 0, 1));
                    return;
                end
                s = find_slot(skey, 0);
                if (s < 0) begin
                    result_q.push_back(mk(ST_NO_POL, 0, 0, 0, 0, 1));
                    return;
                end
                cnt = tbl_total[s];
                if (cnt == 0) begin
                    result_q.push_back(mk(ST_NOTHING, 0, 0, 0, 0, 1));
                    return;
                end
                emit = (cnt < maxc) ? cnt : maxc;
                foreach (taken[i]) taken[i] = 0;
                // best remaining, first index on ties: stable descending order
                for (int k = 0; k < emit; k++) begin
                    best = -1;
                    for (int i = 0; i < cnt; i++) begin
                        if (!taken[i] && (best < 0 || tbl_q[s][i] > tbl_q[s][best]))
                            best = i;
                    end
                    taken[best] = 1;
                    result_q.push_back(mk(ST_OK, tbl_act[s][best], 0, 0, 0, k + 1 == emit));
                end
            end
        endcase
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t e;
        if (!aresetn) begin
            used = 0;
            foreach (tbl_total[i]) tbl_total[i] = 0;
            result_q.delete();
        end else begin
            if (s_tvalid && s_tready) predict_request(192'(s_tdata));
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $error("result item with no prediction waiting");
                    fail_count++;
                end else begin
                    e = result_q.pop_front();
                    check_field("status", e.status, m_tdata[1:0]);
                    check_field("chosen_action", e.action, m_tdata[65:2]);
                    check_field("policy_number", e.pol, m_tdata[79:66]);
                    check_field("new_q", e.q, m_tdata[111:80]);
                    check_field("explored", e.expl, m_tuser);
                    check_field("last", e.last, m_tlast);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Q-learning table engine: directed corner requests, then
// random request streams over a small pool of states and actions, with
// bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import qlte_pkg::*;

    localparam int N_RANDOM   = 95;
    localparam int IDLE_LIMIT = 20000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_BYTES_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_BYTES_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    int                     fail_count;
    int                     pending;
    int                     sent;
    int                     idle_cycles;
    logic [7:0]             state_pool[4];
    logic [63:0]            action_pool[24];

    q_learning_table_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    qlte_checker i_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    task automatic send_request(req_t req, logic [7:0] sk, logic [7:0] nk,
                                logic [63:0] act, logic [31:0] rew, logic [16:0] lr,
                                logic [16:0] eps, logic [15:0] xd, logic [15:0] pd,
                                logic [4:0] maxc, bit gap_after);
        logic [191:0] v;
        v = {7'd0, maxc, pd, xd, eps, lr, rew, act, nk, sk, req};
        s_tvalid <= 1'b1;
        s_tdata  <= v[IN_BYTES_W-1:0];
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (gap_after) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic random_request(bit gap_after);
        req_t        req;
        logic [7:0]  sk, nk;
        logic [63:0] act;
        logic [31:0] rew;
        logic [16:0] lr, eps;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)       req = REQ_CREATE;
        else if (pick < 55) req = REQ_UPDATE;
        else if (pick < 78) req = REQ_SELECT;
        else                req = REQ_LIST;
        sk  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : state_pool[$urandom_range(0, 3)];
        nk  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : state_pool[$urandom_range(0, 3)];
        act = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                          : action_pool[$urandom_range(0, 23)];
        rew = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 20))
                                                            - 10) << 16;
        lr  = ($urandom_range(0, 4) == 0) ? 17'd65536 : 17'($urandom_range(0, 65536));
        eps = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        send_request(req, sk, nk, act, rew, lr, eps, 16'($urandom), 16'($urandom),
                     5'($urandom_range(0, 20) == 0 ? $urandom : $urandom_range(0, 17)),
                     gap_after);
    endtask

    // receiver: random stalls, free-running stretches, one long hold-off
    initial begin
        bit held;
        held = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && sent >= 60) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            case ($urandom_range(0, 2))
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
            repeat ($urandom_range(0, 10)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int burst;
        sent        = 0;
        idle_cycles = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        state_pool = '{8'd0, 8'd7, 8'd128, 8'd255};
        foreach (action_pool[i]) action_pool[i] = {$urandom, $urandom};
        action_pool[0] = '0;
        action_pool[1] = '1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // requests on an empty table
        send_request(REQ_LIST, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0, 5'd1, 1);
        send_request(REQ_UPDATE, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(REQ_SELECT, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0, 0, 1);
        // creates at the extremes, repeated state
        send_request(REQ_CREATE, 8'd0, 0, 0, 0, 17'd65536, 0, 0, 0, 0, 0);
        send_request(REQ_CREATE, 8'd255, 0, 0, 0, 17'd0, 0, 0, 0, 0, 1);
        send_request(REQ_CREATE, 8'd0, 0, 0, 0, 17'd32768, 0, 0, 0, 0, 0);
        // policy without actions
        send_request(REQ_LIST, 8'd0, 0, 0, 0, 0, 0, 0, 0, 5'd16, 0);
        send_request(REQ_SELECT, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        // updates with extreme rewards, next state with and without actions
        send_request(REQ_UPDATE, 8'd0, 8'd0, '1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        send_request(REQ_UPDATE, 8'd0, 8'd0, '1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        send_request(REQ_UPDATE, 8'd0, 8'd0, 64'd0, 32'h8000_0000, 0, 0, 0, 0, 0, 1);
        send_request(REQ_UPDATE, 8'd0, 8'd9, 64'd5, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
        send_request(REQ_UPDATE, 8'd0, 8'd0, 64'd6, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
        send_request(REQ_UPDATE, 8'd255, 8'd0, 64'd9, 32'hFFFF_0000, 0, 0, 0, 0, 0, 1);
        send_request(REQ_UPDATE, 8'd3, 8'd0, 64'd9, 0, 0, 0, 0, 0, 0, 0);
        // select: exploit, explore, epsilon above one
        send_request(REQ_SELECT, 8'd0, 0, 0, 0, 0, 17'd0, 16'hFFFF, 16'hFFFF, 0, 0);
        send_request(REQ_SELECT, 8'd0, 0, 0, 0, 0, 17'd65536, 16'hFFFF, 16'd7, 0, 0);
        send_request(REQ_SELECT, 8'd0, 0, 0, 0, 0, 17'h1FFFF, 16'hFFFF, 16'd2, 0, 1);
        send_request(REQ_SELECT, 8'd7, 0, 0, 0, 0, 17'd0, 0, 0, 0, 0);
        // list: zero, partial, oversized counts, missing policy
        send_request(REQ_LIST, 8'd0, 0, 0, 0, 0, 0, 0, 0, 5'd0, 0);
        send_request(REQ_LIST, 8'd0, 0, 0, 0, 0, 0, 0, 0, 5'd2, 0);
        send_request(REQ_LIST, 8'd0, 0, 0, 0, 0, 0, 0, 0, 5'd31, 1);
        send_request(REQ_LIST, 8'd42, 0, 0, 0, 0, 0, 0, 0, 5'd4, 0);

        // random part, bursts with gaps
        while (sent < N_RANDOM + 23) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) random_request(k == burst - 1);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/qlte_pkg.sv
hdl/qlte_ram.sv
hdl/q_learning_table_engine.sv
bench/qlte_checker.sv
bench/tb_top.sv
